// ----- sv/kkcs_pkg.sv -----
// Shared types and constants for the max-spacing K-clustering block.
package kkcs_pkg;

   // Field widths.
   localparam int PT_W = 16;
   localparam int SQ_W = 33;
   localparam int RT_W = 33;
   localparam int K_W = 9;
   localparam int REM_W = 36;
   localparam int ROOT_STEPS = 33;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Defaults and reset values.
   localparam int MAX_POINTS_DEF = 256;
   localparam logic [K_W-1:0] K_RESET = 9'd2;
   localparam logic [SQ_W-1:0] DIST_MAX = '1;

   // Register index of the cluster count.
   localparam logic CSR_IDX_K = 1'b0;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PICK_RD,
      ST_PICK_LAT,
      ST_SCAN,
      ST_DRAIN,
      ST_REC,
      ST_SEL_RD,
      ST_SEL_LAT,
      ST_SEL_SCAN,
      ST_SEL_DRAIN,
      ST_SEL_CHK,
      ST_ROOT_INIT,
      ST_ROOT,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic pick_rd;
      logic pick_lat;
      logic scan;
      logic rec;
      logic sel_rd;
      logic sel_lat;
      logic sel_scan;
      logic sel_next;
      logic root_init;
      logic root_step;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic no_answer;
      logic scan_last;
      logic pipe_busy;
      logic rounds_last;
      logic sel_last;
      logic sel_busy;
      logic sel_found;
      logic root_last;
      logic out_free;
   } sts_type;

endpackage

// ----- sv/kkcs_ctrl.sv -----
// Controller state machine that sequences load, spanning tree, selection, root and output.
module kkcs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tlast,
   output logic               req_tready,
   input  kkcs_pkg::sts_type  sts,
   output kkcs_pkg::cmd_type  cmd
);
   import kkcs_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tlast) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = sts.no_answer ? ST_OUT : ST_PICK_RD;
         end
         ST_PICK_RD:  state_in = ST_PICK_LAT;
         ST_PICK_LAT: state_in = ST_SCAN;
         ST_SCAN: begin
            if (sts.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) state_in = ST_REC;
         end
         ST_REC: begin
            state_in = sts.rounds_last ? ST_SEL_RD : ST_PICK_RD;
         end
         ST_SEL_RD:  state_in = ST_SEL_LAT;
         ST_SEL_LAT: state_in = ST_SEL_SCAN;
         ST_SEL_SCAN: begin
            if (sts.sel_last) state_in = ST_SEL_DRAIN;
         end
         ST_SEL_DRAIN: begin
            if (!sts.sel_busy) state_in = ST_SEL_CHK;
         end
         ST_SEL_CHK: begin
            state_in = sts.sel_found ? ST_ROOT_INIT : ST_SEL_RD;
         end
         ST_ROOT_INIT: state_in = ST_ROOT;
         ST_ROOT: begin
            if (sts.root_last) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_PICK_RD:   cmd.pick_rd = 1'b1;
         ST_PICK_LAT:  cmd.pick_lat = 1'b1;
         ST_SCAN:      cmd.scan = 1'b1;
         ST_REC:       cmd.rec = 1'b1;
         ST_SEL_RD:    cmd.sel_rd = 1'b1;
         ST_SEL_LAT:   cmd.sel_lat = 1'b1;
         ST_SEL_SCAN:  cmd.sel_scan = 1'b1;
         ST_SEL_CHK:   cmd.sel_next = !sts.sel_found;
         ST_ROOT_INIT: cmd.root_init = 1'b1;
         ST_ROOT:      cmd.root_step = 1'b1;
         ST_OUT:       cmd.out_load = sts.out_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- sv/kkcs_dpath.sv -----
// Datapath: point store, spanning-tree scan pipeline, weight selection, root unit, output.
module kkcs_dpath #(
   parameter int MAX_POINTS = kkcs_pkg::MAX_POINTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  kkcs_pkg::cmd_type                 cmd,
   output kkcs_pkg::sts_type                 sts,
   input  logic [kkcs_pkg::K_W-1:0]          k_clusters,
   input  logic [kkcs_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [kkcs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser
);
   import kkcs_pkg::*;

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int WW = ((CW > K_W) ? CW : K_W) + 1;

   // Memories.
   logic signed [PT_W-1:0] x_mem [MAX_POINTS];
   logic signed [PT_W-1:0] y_mem [MAX_POINTS];
   logic [SQ_W:0]          best_mem [MAX_POINTS];
   logic [SQ_W-1:0]        w_mem [MAX_POINTS];

   logic signed [PT_W-1:0] rdx_ff, rdy_ff;
   logic [SQ_W:0]          best_rd_ff;
   logic [SQ_W-1:0]        w_rd_ff;

   // Load and set control.
   logic [CW-1:0] count_ff;
   logic [CW-1:0] n_ff;
   logic [CW-1:0] idx_ff;
   logic          noans_ff;
   logic [CW-1:0] n_new;
   logic          store_ok;
   logic [WW-1:0] k_ext, n_ext;

   // Spanning-tree scan.
   logic [AW-1:0]          pick_ff, i_ff, round_ff;
   logic signed [PT_W-1:0] px_ff, py_ff;
   logic                   first_ff;
   logic [SQ_W-1:0]        bmin_ff;
   logic [AW-1:0]          bsel_ff;

   logic                   s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic [AW-1:0]          s1_i_ff, s2_i_ff, s3_i_ff, s4_i_ff;
   logic signed [PT_W:0]   dx_ff, dy_ff;
   logic                   s2_tree_ff, s3_tree_ff;
   logic [SQ_W-1:0]        s2_best_ff, s3_best_ff;
   logic [2*PT_W-1:0]      sqx_ff, sqy_ff;
   logic [SQ_W-1:0]        s4_nd_ff;
   logic                   s4_cand_ff;

   logic signed [PT_W:0]   dx_in, dy_in;
   logic [2*PT_W+1:0]      sqx_full, sqy_full;
   logic [SQ_W-1:0]        d3, nd3;
   logic                   cand3;

   // Selection.
   logic [AW-1:0]   c_ff, j_ff;
   logic [SQ_W-1:0] wc_ff;
   logic [CW-1:0]   lt_ff, le_ff;
   logic            sv1_ff;

   // Root unit.
   logic [SQ_W:0]     dsh_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [RT_W-1:0]   root_ff;
   logic [5:0]        rcnt_ff;
   logic [REM_W-1:0]  rem_sh, trial;

   // Output register.
   logic            rsp_valid_ff;
   logic [SQ_W-1:0] out_sq_ff;
   logic [RT_W-1:0] out_rt_ff;
   logic            out_ok_ff;

   logic [AW-1:0] pt_raddr, w_raddr;

   // Point admission and answer check for the item that ends the set.
   assign store_ok = count_ff < CW'(MAX_POINTS);
   assign n_new = store_ok ? count_ff + CW'(1) : count_ff;
   assign k_ext = WW'(k_clusters);
   assign n_ext = WW'(n_new);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         n_ff <= '0;
         idx_ff <= '0;
         noans_ff <= 1'b0;
      end else if (cmd.accept) begin
         if (req_tlast) begin
            count_ff <= '0;
            n_ff <= n_new;
            idx_ff <= CW'(n_ext - k_ext);
            noans_ff <= (k_ext < WW'(2)) || (k_ext > n_ext);
         end else begin
            count_ff <= n_new;
         end
      end
   end

   // Point store: written on load, one read port shared by pick fetch and scan.
   assign pt_raddr = cmd.pick_rd ? pick_ff : i_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept && store_ok) begin
         x_mem[count_ff[AW-1:0]] <= req_tdata[PT_W-1:0];
         y_mem[count_ff[AW-1:0]] <= req_tdata[2*PT_W-1:PT_W];
      end
      rdx_ff <= x_mem[pt_raddr];
      rdy_ff <= y_mem[pt_raddr];
   end

   // Tree flag and best distance per point.
   always_ff @(posedge clock) begin
      if (s3_v_ff && !s3_tree_ff) begin
         best_mem[s3_i_ff] <= {(s3_i_ff == pick_ff), nd3};
      end
      best_rd_ff <= best_mem[i_ff];
   end

   // Scan control: pick, index, round, running minimum.
   always_ff @(posedge clock) begin
      if (reset) begin
         pick_ff <= '0;
         i_ff <= '0;
         round_ff <= '0;
         first_ff <= 1'b1;
      end else begin
         if (cmd.accept) begin
            pick_ff <= '0;
            round_ff <= '0;
            first_ff <= 1'b1;
         end
         if (cmd.pick_lat) i_ff <= '0;
         if (cmd.scan) i_ff <= i_ff + AW'(1);
         if (cmd.rec) begin
            pick_ff <= bsel_ff;
            round_ff <= round_ff + AW'(1);
            first_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pick_lat) begin
         px_ff <= rdx_ff;
         py_ff <= rdy_ff;
         bmin_ff <= DIST_MAX;
         bsel_ff <= '0;
      end else if (s4_v_ff && s4_cand_ff && (s4_nd_ff <= bmin_ff)) begin
         bmin_ff <= s4_nd_ff;
         bsel_ff <= s4_i_ff;
      end
   end

   // Scan pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= cmd.scan;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   // Differences, squares, then sum with minimum update.
   assign dx_in = (PT_W+1)'(rdx_ff) - (PT_W+1)'(px_ff);
   assign dy_in = (PT_W+1)'(rdy_ff) - (PT_W+1)'(py_ff);
   assign sqx_full = dx_ff * dx_ff;
   assign sqy_full = dy_ff * dy_ff;
   assign d3 = SQ_W'(sqx_ff) + SQ_W'(sqy_ff);
   assign nd3 = (d3 < s3_best_ff) ? d3 : s3_best_ff;
   assign cand3 = !s3_tree_ff && (s3_i_ff != pick_ff);

   always_ff @(posedge clock) begin
      s1_i_ff <= i_ff;
      s2_i_ff <= s1_i_ff;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      s2_tree_ff <= first_ff ? 1'b0 : best_rd_ff[SQ_W];
      s2_best_ff <= first_ff ? DIST_MAX : best_rd_ff[SQ_W-1:0];
      s3_i_ff <= s2_i_ff;
      s3_tree_ff <= s2_tree_ff;
      s3_best_ff <= s2_best_ff;
      sqx_ff <= sqx_full[2*PT_W-1:0];
      sqy_ff <= sqy_full[2*PT_W-1:0];
      s4_i_ff <= s3_i_ff;
      s4_nd_ff <= nd3;
      s4_cand_ff <= cand3;
   end

   // Tree weights: written per round, one read port shared by candidate and scan.
   assign w_raddr = cmd.sel_rd ? c_ff : j_ff;

   always_ff @(posedge clock) begin
      if (cmd.rec) w_mem[round_ff] <= bmin_ff;
      w_rd_ff <= w_mem[w_raddr];
   end

   // Selection: count weights below and up to each candidate.
   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff <= '0;
         j_ff <= '0;
         sv1_ff <= 1'b0;
      end else begin
         sv1_ff <= cmd.sel_scan;
         if (cmd.accept) c_ff <= '0;
         if (cmd.sel_next) c_ff <= c_ff + AW'(1);
         if (cmd.sel_lat) j_ff <= '0;
         if (cmd.sel_scan) j_ff <= j_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sel_lat) begin
         wc_ff <= w_rd_ff;
         lt_ff <= '0;
         le_ff <= '0;
      end else if (sv1_ff) begin
         lt_ff <= lt_ff + CW'(w_rd_ff < wc_ff);
         le_ff <= le_ff + CW'(w_rd_ff <= wc_ff);
      end
   end

   // Square root, two radicand bits per step.
   assign rem_sh = {rem_ff[REM_W-3:0], dsh_ff[SQ_W:SQ_W-1]};
   assign trial = {1'b0, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.root_init) begin
         dsh_ff <= {1'b0, wc_ff};
         rem_ff <= '0;
         root_ff <= '0;
         rcnt_ff <= '0;
      end else if (cmd.root_step) begin
         dsh_ff <= {dsh_ff[SQ_W-2:0], 2'b00};
         rcnt_ff <= rcnt_ff + 6'd1;
         if (rem_sh >= trial) begin
            rem_ff <= rem_sh - trial;
            root_ff <= {root_ff[RT_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            root_ff <= {root_ff[RT_W-2:0], 1'b0};
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_sq_ff <= noans_ff ? '0 : wc_ff;
         out_rt_ff <= noans_ff ? '0 : root_ff;
         out_ok_ff <= !noans_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_W-SQ_W-RT_W){1'b0}}, out_rt_ff, out_sq_ff};
   assign rsp_tuser = out_ok_ff;

   // Status.
   always_comb begin
      sts.no_answer = noans_ff;
      sts.scan_last = (CW'(i_ff) == n_ff - CW'(1));
      sts.pipe_busy = s1_v_ff || s2_v_ff || s3_v_ff || s4_v_ff;
      sts.rounds_last = (CW'(round_ff) == n_ff - CW'(2));
      sts.sel_last = (CW'(j_ff) == n_ff - CW'(2));
      sts.sel_busy = sv1_ff;
      sts.sel_found = (lt_ff <= idx_ff) && (idx_ff < le_ff);
      sts.root_last = (rcnt_ff == 6'(ROOT_STEPS - 1));
      sts.out_free = !rsp_valid_ff || rsp_tready;
   end

endmodule

// ----- sv/kruskal_k_clustering_spacing.sv -----
// Points load one item per cycle while idle. The last item starts V-1 tree scans, then up
// to V-1 selection passes, the square root and the output load. The scan and selection
// loops each read their memories at one index per cycle.
// Input stalls from the last item until its result is loaded into the output register.
// Reset is synchronous active high: clears the point count, control and K to 2.
module kruskal_k_clustering_spacing #(
   parameter int MAX_POINTS = kkcs_pkg::MAX_POINTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input item: point_x [15:0], point_y [31:16].
   input  logic [kkcs_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_tlast,
   // Result item: spacing_squared [32:0], spacing_root [65:33], zero fill [71:66].
   output logic [kkcs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Result flag: answer_valid [0].
   output logic                              rsp_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Configuration port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [kkcs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [kkcs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [kkcs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import kkcs_pkg::*;

   logic [K_W-1:0] k_ff;
   cmd_type        cmd;
   sts_type        sts;
   logic           hit_k;

   // Cluster count register.
   assign csr_pready = 1'b1;
   assign hit_k = (csr_paddr[2] == CSR_IDX_K);

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= K_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && hit_k) begin
         k_ff <= csr_pwdata[K_W-1:0];
      end
   end

   assign csr_prdata = hit_k ? CSR_DATA_W'(k_ff) : '0;

   kkcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   kkcs_dpath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .k_clusters (k_ff),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
